[rtl/assert_macros.svh]
// Assertion helper macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication check on the rising clock edge, masked while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check of the next cycle on the rising clock edge, masked while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// sha512_pkg
// Types, constants and round functions shared by the SHA-512 digest block.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WORD_W = 64;
    localparam int NUM_ROUNDS = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS = 8;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int BLOCK_BYTES = 1024 / 8;
    localparam int LENGTH_BYTES = 128 / 8;
    localparam int PAD_LIMIT = BLOCK_BYTES - LENGTH_BYTES;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Requests from the sequencer to the round unit.
    typedef struct packed {
        logic       load;
        logic       round;
        logic       fold;
        logic       reinit;
        logic [6:0] round_index;
    } t_round_ctl;

    localparam logic [63:0] INIT_VALUE [HASH_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [NUM_ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] sig0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sig1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

[rtl/sha512_round.sv]
// ----------------------------------------------------------------------------
// sha512_round
// Shared round unit: working variables, chaining words and one round a cycle.
// ----------------------------------------------------------------------------
module sha512_round (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sha512_pkg::t_round_ctl  i_ctl,
    input  logic [63:0]             i_w,
    input  logic [2:0]              i_rd_idx,
    output logic [63:0]             o_hash
);
    import sha512_pkg::*;

    logic [63:0] r_h [HASH_WORDS];
    logic [63:0] r_v [HASH_WORDS];
    logic [63:0] t1, t2;

    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + ROUND_K[i_ctl.round_index] + i_w;
        t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            for (int i = 0; i < HASH_WORDS; i++) r_h[i] <= INIT_VALUE[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < HASH_WORDS; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < HASH_WORDS; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash = r_h[i_rd_idx];

endmodule

[rtl/sha512_message_digest.sv]
// ----------------------------------------------------------------------------
// sha512_message_digest
// SHA-512 digest of a byte stream packed into 64-bit words.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | sink      | message_word, byte_count, last_word
// out     | source    | digest_word, word_index, last_digest
//
// A beat is taken in an idle cycle; its bytes are then packed one a cycle,
// held while a completed block is compressed, and the block then returns to
// idle. A beat that completes a block runs the rounds and then a fold in the
// shared round unit. Padding inserts one byte a cycle, again held while a block
// is compressed, so a last beat can take padding plus one or two block
// compressions, then eight output beats.
// Reset is synchronous and active low; output stalls simply hold the beat.
`include "assert_macros.svh"
module sha512_message_digest (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sha512_pkg::t_in_beat   i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sha512_pkg::t_out_beat  o_data
);
    import sha512_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_buf [BLOCK_WORDS];
    logic [3:0]  r_wc;
    logic [2:0]  r_pb;
    logic [127:0] r_len;
    logic [6:0]  r_rnd;
    logic [3:0]  r_bytes;      // bytes of the current beat still to push
    logic [63:0] r_word;
    logic        r_last;
    logic        r_padding;    // pad mark already pushed
    logic        r_lenblk;     // compressing the final block
    logic [2:0]  r_oidx;

    t_round_ctl  ctl;
    logic [63:0] w_val, hash;
    logic [3:0]  t;
    logic [63:0] new_w;
    logic        push;
    logic [7:0]  pbyte;
    logic [6:0]  fill;

    assign t = r_rnd[3:0];
    assign new_w = r_buf[t] + sig0(r_buf[t + 4'd1]) + r_buf[t + 4'd9] + sig1(r_buf[t + 4'd14]);
    assign w_val = (r_rnd < 7'd16) ? r_buf[t] : new_w;
    assign fill = {r_wc, r_pb};

    sha512_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_w      (w_val),
        .i_rd_idx (r_oidx),
        .o_hash   (hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Control: byte pushing happens in ST_PAD, one byte per cycle.
    always_comb begin
        n_state = r_state;
        ctl = '0;
        ctl.round_index = r_rnd;
        push = 1'b0;
        pbyte = '0;
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        o_data.digest_word = hash;
        o_data.word_index = r_oidx;
        o_data.last_digest = (r_oidx == 3'd7);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_PAD;
            end
            ST_PAD: begin
                if (r_bytes != 4'd0) begin
                    push = 1'b1;
                    pbyte = r_word[63:56];
                end else if (r_last && !r_padding) begin
                    push = 1'b1;
                    pbyte = PAD_MARK;
                end else if (r_last && fill != 7'(PAD_LIMIT)) begin
                    push = 1'b1;
                end else if (r_last) begin
                    ctl.load = 1'b1;
                    n_state = ST_ROUND;
                end else begin
                    n_state = ST_IDLE;
                end
                if (push && r_pb == 3'd7 && r_wc == 4'd15) begin
                    ctl.load = 1'b1;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.round = 1'b1;
                if (r_rnd == 7'(NUM_ROUNDS - 1)) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                n_state = r_lenblk ? ST_EMIT : ST_PAD;
            end
            ST_EMIT: begin
                if (i_ready && r_oidx == 3'd7) begin
                    ctl.reinit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (r_pb == 3'd0) r_buf[r_wc] <= {pbyte, 56'd0};
            else r_buf[r_wc] <= r_buf[r_wc] | ({pbyte, 56'd0} >> {r_pb, 3'd0});
        end
        if (r_state == ST_ROUND && r_rnd >= 7'd16) r_buf[t] <= new_w;
        if (r_state == ST_PAD && r_last && r_padding && r_bytes == 4'd0
            && fill == 7'(PAD_LIMIT)) begin
            r_buf[14] <= r_len[127:64];
            r_buf[15] <= r_len[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
            r_pb <= '0;
            r_len <= '0;
            r_rnd <= '0;
            r_bytes <= '0;
            r_last <= 1'b0;
            r_padding <= 1'b0;
            r_lenblk <= 1'b0;
            r_oidx <= '0;
        end else begin
            if (r_state == ST_IDLE && i_valid) begin
                r_word <= i_data.message_word;
                r_bytes <= (i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count;
                r_last <= i_data.last_word;
                r_len <= r_len + {121'd0,
                    ((i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count), 3'd0};
            end
            if (push) begin
                r_pb <= r_pb + 3'd1;
                if (r_pb == 3'd7) r_wc <= r_wc + 4'd1;
                if (r_bytes != 4'd0) begin
                    r_bytes <= r_bytes - 4'd1;
                    r_word <= {r_word[55:0], 8'd0};
                end else if (!r_padding) begin
                    r_padding <= 1'b1;
                end
            end
            if (r_state == ST_PAD && r_last && r_padding && r_bytes == 4'd0
                && fill == 7'(PAD_LIMIT) && !push) r_lenblk <= 1'b1;
            if (r_state == ST_ROUND)
                r_rnd <= (r_rnd == 7'(NUM_ROUNDS - 1)) ? 7'd0 : r_rnd + 7'd1;
            if (r_state == ST_EMIT && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_wc <= '0;
                    r_pb <= '0;
                    r_len <= '0;
                    r_last <= 1'b0;
                    r_padding <= 1'b0;
                    r_lenblk <= 1'b0;
                end
            end
        end
    end

    `ASSERT_IMPL(a_round_busy, i_clk, i_rst_n, r_state == ST_ROUND, !o_ready && !o_valid)
    `ASSERT_NEXT(a_emit_wrap, i_clk, i_rst_n, o_valid && i_ready && o_data.last_digest,
        r_state == ST_IDLE && r_oidx == 3'd0)
    `ASSERT_IMPL(a_idx_idle, i_clk, i_rst_n, r_state != ST_EMIT, r_oidx == 3'd0)
    `ASSERT_IMPL(a_fold_last, i_clk, i_rst_n, r_state == ST_FOLD, r_rnd == 7'd0)

endmodule
